// ----- design/assert_macros.svh -----
// Assertion macros for the design files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising clock edge, masked while reset is asserted.
`define GMPS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("gmps assertion failed");

// Check sampled on the rising clock edge, also active during reset.
`define GMPS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("gmps assertion failed");

`endif

// ----- design/gmps_pkg.sv -----
// Types, constants and the saturating adder for the grid path-sum block.
// No dependencies.
package gmps_pkg;

    localparam int COST_W  = 16;
    localparam int SUM_W   = 32;
    localparam int WIDTH_W = 9;

    typedef logic [COST_W-1:0]  cost_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [WIDTH_W-1:0] row_width_t;

    localparam sum_t SUM_MAX = '1;

    // a + b, clamped at the top of the sum range
    function automatic sum_t sat_add(input sum_t a, input cost_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-COST_W){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ----- design/gmps_ifs.sv -----
// Valid/ready channel interfaces: cell words in, path sums out, row width config.
// Depends on gmps_pkg.
interface gmps_cell_if;
    logic               valid;
    logic               ready;
    gmps_pkg::cost_t    cell_cost;
    logic               last_cell;

    modport source (output valid, output cell_cost, output last_cell, input ready);
    modport sink   (input valid, input cell_cost, input last_cell, output ready);
endinterface

interface gmps_sum_if;
    logic               valid;
    logic               ready;
    gmps_pkg::sum_t     path_sum;

    modport source (output valid, output path_sum, input ready);
    modport sink   (input valid, input path_sum, output ready);
endinterface

interface gmps_cfg_if;
    logic                   valid;
    logic                   ready;
    gmps_pkg::row_width_t   row_width;

    modport source (output valid, output row_width, input ready);
    modport sink   (input valid, input row_width, output ready);
endinterface

// ----- design/gmps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/grid_min_path_sum_top.sv -----
// Minimum path sum over a streamed grid: top level.
// Depends on gmps_pkg, gmps_ifs, gmps_ram and assert_macros.svh.
//
// Usage:
//   cells : one word per grid cell, row-major, last_cell set on the final cell.
//   sums  : one word per grid, the minimum path cost to the marked cell,
//           saturating at 0xFFFFFFFF.
//   cfg   : row_width write (0 acts as 1, above MAX_COLS clamps). A write
//           abandons any grid in progress; write only while the block is idle.
// Timing:
//   One cell word accepted per cycle while cells.ready is high. Each cell does one
//   row-buffer read (issued at accept) and one compare/add/write-back in stage 1, so
//   the row buffer's one read and one write port set the one-cell-per-cycle rate.
//   path_sum is registered: the marked cell passes stage 1, then the output register.
//   Same-column back-to-back reads (row width 1) go through a forwarding register.
// Reset: control state clears at once; row width returns to 1 and the next cell
//   starts a new grid. The row buffer is not cleared: entries are always written
//   in the current grid before they are read.
// Stall: the result sits in an output register; cells keep flowing until a
//   second marked cell would need that register, then cells.ready drops.
`include "assert_macros.svh"

module grid_min_path_sum_top #(
    parameter int MAX_COLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    gmps_cell_if.sink   cells,
    gmps_sum_if.source  sums,
    gmps_cfg_if.sink    cfg
);

    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int WID_W  = (CNT_W > gmps_pkg::WIDTH_W) ? CNT_W : gmps_pkg::WIDTH_W;

    typedef logic [ADDR_W-1:0] col_t;
    typedef logic [WID_W-1:0]  wid_t;

    // ---------------- configuration ----------------
    // row_width_reg holds the effective (clamped) row width
    wid_t row_width_reg;
    wid_t cfg_width;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_width = WID_W'(cfg.row_width);
        if (cfg.row_width == '0)
        begin
            cfg_width = WID_W'(1);
        end
        else if (WID_W'(cfg.row_width) > WID_W'(MAX_COLS))
        begin
            cfg_width = WID_W'(MAX_COLS);
        end
    end

    // ---------------- stage 0: column tracking, buffer read ----------------
    col_t  col_reg, col_next;
    logic  first_row_reg, first_row_next;
    logic  in_accept;
    logic  row_end;

    // stage 1 registers
    logic             s1_valid_reg;
    col_t             s1_col_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    gmps_pkg::cost_t  s1_cost_reg;
    logic             fwd_hit_reg;
    gmps_pkg::sum_t   fwd_data_reg;

    logic             s1_go;
    gmps_pkg::sum_t   ram_rdata;
    gmps_pkg::sum_t   above;
    gmps_pkg::sum_t   base;
    gmps_pkg::sum_t   cell_sum;
    gmps_pkg::sum_t   left_reg;

    logic             out_valid_reg;
    gmps_pkg::sum_t   out_sum_reg;

    assign in_accept   = cells.valid && cells.ready;
    assign cells.ready = !s1_valid_reg || s1_go;
    assign row_end     = (WID_W'(col_reg) + WID_W'(1)) == row_width_reg;

    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (cfg.valid && cfg.ready)
        begin
            col_next       = '0;
            first_row_next = 1'b1;
        end
        else if (in_accept)
        begin
            if (cells.last_cell)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (row_end)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WID_W'(1);
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                row_width_reg <= cfg_width;
            end
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                // the write retiring now lands after this read samples the RAM
                fwd_hit_reg  <= s1_go && (s1_col_reg == col_reg);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg   <= col_reg;
            s1_first_reg <= first_row_reg;
            s1_last_reg  <= cells.last_cell;
            s1_cost_reg  <= cells.cell_cost;
            fwd_data_reg <= cell_sum;
        end
    end

    gmps_ram #(
        .WIDTH (gmps_pkg::SUM_W),
        .DEPTH (MAX_COLS)
    ) u_row_buf (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (cell_sum),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    // ---------------- stage 1: min, add, write back ----------------
    // only a marked cell needs the output register
    assign s1_go = s1_valid_reg && (!s1_last_reg || !out_valid_reg || sums.ready);
    assign above = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        if (s1_first_reg)
        begin
            base = (s1_col_reg == '0) ? '0 : left_reg;
        end
        else if (s1_col_reg == '0)
        begin
            base = above;
        end
        else
        begin
            base = (above < left_reg) ? above : left_reg;
        end
    end

    assign cell_sum = gmps_pkg::sat_add(base, s1_cost_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (s1_go)
        begin
            left_reg <= cell_sum;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sums.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_sum_reg <= cell_sum;
        end
    end

    assign sums.valid    = out_valid_reg;
    assign sums.path_sum = out_sum_reg;

    // ---------------- checks ----------------
    `GMPS_ASSERT(a_s1_stall_only_on_full_out, clk, rst_n, (s1_valid_reg && !s1_go) |-> (s1_last_reg && out_valid_reg && !sums.ready))
    `GMPS_ASSERT(a_restart_after_marker, clk, rst_n, (in_accept && cells.last_cell && !cfg.valid) |=> (col_reg == '0 && first_row_reg))
    `GMPS_ASSERT_ALWAYS(a_col_in_row, clk, (WID_W'(col_reg) < row_width_reg) || !rst_n)

endmodule
